// ----- hw/rtl/crt_pkg.sv -----
// Shared types, constants and the weight-rounding function for the Catmull-Rom tessellator.
// Used by the controller, the divider, the datapath, the top level and the testbench. Depends on nothing else.
package crt_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_SEG_DEFAULT = 63;
	localparam int COORD_BITS_DEFAULT = 16;

	// The segment count register: width and value after reset.
	localparam int SEG_W = 6;
	localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;

	// Parameter t in Q1.16, and the basis weights in signed Q2.16.
	localparam int T_W = 17;
	localparam int W_W = 18;
	localparam logic [T_W-1:0] T_ONE = 17'h10000;
	localparam logic signed [W_W-1:0] W_ONE = 18'sh10000;

	// Width of the exact basis polynomials, twice their value in Q48.
	localparam int POLY_W = 52;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // accept a point: shift it in and restart t
		logic issue;  // start one output point down the pipeline
		logic p1;     // the point is the second control point, unchanged
		logic last;   // the point is the last one for this input word
	} crt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pipe_busy;  // a point still needs the control points
		logic advance;    // the pipeline moves at this edge
	} crt_status_t;

	// Rounds twice a weight in Q48 to Q2.16, to nearest with halves up.
	function automatic logic signed [W_W-1:0] round_weight(input logic signed [POLY_W-1:0] v);
		logic signed [POLY_W-1:0] sum;
		sum = v + 52'sd4294967296;
		return sum[W_W+32:33];
	endfunction

endpackage

// ----- hw/rtl/catmull_rom_tessellator_core.sv -----
// Top level of the uniform Catmull-Rom tessellator.
// Joins the controller, the step divider and the datapath. Depends on crt_pkg.
//
// Use: control points arrive as words on the input channel (point_x, point_y,
// new_curve) and tessellated points leave as words on the output channel
// (out_x, out_y, last_of_run); both use valid and ready. The segment count is
// written through its own channel, which is always ready, while the block is idle.
// The first three points of a curve give no output word. Each later point gives
// n words, n being the clamped segment count, and the first full segment of a
// curve is preceded by one more word holding the second control point itself.
// The last word of each input word carries last_of_run.
// Timing: after reset and after every segment count write, a serial divider
// finds the t step, and in_ready stays low until it is done. A word that gives
// no output leaves the block idle, ready for the next word. A word that gives
// output is followed by no other until all its points are issued and have left
// stages s1 to s4; output words come one per cycle while the receiver is ready.
// Throughput is set by the one output point the pipeline starts each cycle it advances.
// If the receiver stalls, the whole pipeline holds and no word is lost.
// Reset clears the window bookkeeping and loads a segment count of 16.
module catmull_rom_tessellator_core #(
	parameter int MAX_SEGMENTS = crt_pkg::MAX_SEG_DEFAULT,
	parameter int COORD_BITS = crt_pkg::COORD_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [crt_pkg::SEG_W-1:0]    segment_count,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         new_curve,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         last_of_run
);
	import crt_pkg::*;

	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

	crt_cmd_t         cmd;
	crt_status_t      status;
	logic             div_start;
	logic             div_busy;
	logic [CNT_W-1:0] seg_n;
	logic [T_W-1:0]   step_q16;
	logic [CNT_W-1:0] step_rem;

	// Sequencing of input words and output points.
	crt_ctrl #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.CNT_W(CNT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.segment_count(segment_count),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.new_curve(new_curve),
		.div_start(div_start),
		.div_busy(div_busy),
		.seg_n(seg_n),
		.cmd(cmd),
		.status(status)
	);

	// Step of t for the current segment count.
	crt_div #(
		.CNT_W(CNT_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.divisor(seg_n),
		.busy(div_busy),
		.quotient(step_q16),
		.remainder(step_rem)
	);

	// Weights, blending and the output register.
	crt_datapath #(
		.COORD_BITS(COORD_BITS),
		.CNT_W(CNT_W)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.seg_n(seg_n),
		.step_q16(step_q16),
		.step_rem(step_rem),
		.point_x(point_x),
		.point_y(point_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.last_of_run(last_of_run)
	);

endmodule

// ----- hw/rtl/crt_div.sv -----
// Serial restoring divider that finds 65536 / n and 65536 % n, one quotient bit per cycle.
// Depends on crt_pkg for the width of t.
module crt_div #(
	parameter int CNT_W = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CNT_W-1:0]      divisor,
	output logic                  busy,
	output logic [crt_pkg::T_W-1:0] quotient,
	output logic [CNT_W-1:0]      remainder
);
	import crt_pkg::*;

	localparam int STEP_W = $clog2(T_W);
	localparam logic [T_W-1:0] DIVIDEND = T_ONE;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [T_W-1:0]    quo_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	// One trial subtraction per cycle, dividend bits taken from the top.
	assign trial = {rem_q, DIVIDEND[step_q]};
	assign fits = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(T_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// Partial remainder and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= CNT_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
			quo_q <= {quo_q[T_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// ----- hw/rtl/crt_ctrl.sv -----
// Controller of the tessellator: segment count register, curve bookkeeping and
// the sequence of output points for each input word. Depends on crt_pkg.
module crt_ctrl #(
	parameter int MAX_SEGMENTS = 63,
	parameter int CNT_W = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [crt_pkg::SEG_W-1:0] segment_count,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     new_curve,
	output logic                     div_start,
	input  logic                     div_busy,
	output logic [CNT_W-1:0]         seg_n,
	output crt_pkg::crt_cmd_t        cmd,
	input  crt_pkg::crt_status_t     status
);
	import crt_pkg::*;

	typedef enum logic [1:0] {
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_IDLE,
		ST_EMIT
	} state_t;

	// Segment count as used: zero counts as one, large values are clamped.
	function automatic logic [CNT_W-1:0] clamp_seg(input logic [SEG_W-1:0] v);
		if (v == '0) begin
			return CNT_W'(1);
		end else if (v > SEG_W'(MAX_SEGMENTS)) begin
			return CNT_W'(MAX_SEGMENTS);
		end else begin
			return CNT_W'(v);
		end
	endfunction

	state_t           state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] j_q;
	logic [1:0]       seen_q;
	logic             primed_q;
	logic             pend_p1_q;
	logic             accept;
	logic [1:0]       seen_eff;
	logic             primed_eff;

	// An input word waits while a segment count write is offered.
	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && !status.pipe_busy && !cfg_valid;
	assign accept = in_valid && in_ready;

	// A new curve empties the window before the point is counted.
	assign seen_eff = new_curve ? 2'd0 : seen_q;
	assign primed_eff = new_curve ? 1'b0 : primed_q;

	// Commands to the datapath.
	assign div_start = (state_q == ST_DIV_GO);
	assign seg_n = n_q;
	assign cmd.load = accept;
	assign cmd.issue = (state_q == ST_EMIT) && status.advance;
	assign cmd.p1 = pend_p1_q;
	assign cmd.last = !pend_p1_q && (j_q == n_q);

	// State and bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DIV_GO;
			n_q <= clamp_seg(SEG_RESET);
			j_q <= '0;
			seen_q <= 2'd0;
			primed_q <= 1'b0;
			pend_p1_q <= 1'b0;
		end else if (cfg_valid) begin
			n_q <= clamp_seg(segment_count);
			state_q <= ST_DIV_GO;
		end else begin
			unique case (state_q)
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (!div_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						primed_q <= (seen_eff == 2'd3) || primed_eff;
						seen_q <= (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;
						if (seen_eff == 2'd3) begin
							pend_p1_q <= !primed_eff;
							j_q <= CNT_W'(1);
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (status.advance) begin
						if (pend_p1_q) begin
							pend_p1_q <= 1'b0;
						end else begin
							j_q <= j_q + 1'b1;
							if (j_q == n_q) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/crt_datapath.sv -----
// Datapath of the tessellator: control point window, t stepping, basis weights,
// blending, rounding, saturation and the output register. Depends on crt_pkg.
module crt_datapath #(
	parameter int COORD_BITS = 16,
	parameter int CNT_W = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  crt_pkg::crt_cmd_t            cmd,
	output crt_pkg::crt_status_t         status,
	input  logic [CNT_W-1:0]             seg_n,
	input  logic [crt_pkg::T_W-1:0]      step_q16,
	input  logic [CNT_W-1:0]             step_rem,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         last_of_run
);
	import crt_pkg::*;

	typedef enum logic [1:0] {
		WSEL_CURVE,
		WSEL_P1,
		WSEL_END
	} wsel_t;

	localparam int PROD_W = COORD_BITS + W_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int RND_W = SUM_W - 16;
	localparam logic signed [POLY_W-1:0] TWO_Q48 = 52'sh2000000000000;
	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	// The four newest control points, index 3 newest.
	logic signed [COORD_BITS-1:0] px_q [4];
	logic signed [COORD_BITS-1:0] py_q [4];

	// t stepping state.
	logic [T_W-1:0]   t_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W:0]   r_sum;
	logic             r_wrap;
	logic [T_W-1:0]   t_next;

	// Pipeline registers.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	logic p1_s1;
	logic [T_W-1:0] t_s1;
	wsel_t wsel_s2, wsel_s3;
	logic [15:0] t_s2, t_s3;
	logic [31:0] t2_s2, t2_s3;
	logic [47:0] t3_s3;
	logic signed [W_W-1:0] b_s4 [4];
	logic signed [PROD_W-1:0] prx_s5 [4];
	logic signed [PROD_W-1:0] pry_s5 [4];
	logic out_valid_q, last_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;

	logic advance;

	// The whole pipeline moves whenever the output register can take a word.
	assign advance = !out_valid_q || out_ready;
	assign status.advance = advance;
	assign status.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;

	// Next t: add the step quotient, carry the remainder once it reaches n.
	assign r_sum = {1'b0, r_q} + {1'b0, step_rem};
	assign r_wrap = r_sum >= {1'b0, seg_n};
	assign t_next = t_q + step_q16 + {{(T_W-1){1'b0}}, r_wrap};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q <= '0;
			r_q <= seg_n >> 1;
		end else if (cmd.issue && !cmd.p1) begin
			t_q <= t_next;
			r_q <= r_wrap ? CNT_W'(r_sum - {1'b0, seg_n}) : r_sum[CNT_W-1:0];
		end
	end

	// Window of control points, shifted on each accepted word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				px_q[i] <= px_q[i+1];
				py_q[i] <= py_q[i+1];
			end
			px_q[3] <= point_x;
			py_q[3] <= point_y;
		end
	end

	// Valid bits of the pipeline and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// Weight polynomials in twice Q48, from the registered powers of t.
	logic signed [POLY_W-1:0] pt3, pt2, pt1;
	logic signed [POLY_W-1:0] poly [4];

	always_comb begin
		pt3 = signed'({4'b0, t3_s3});
		pt2 = signed'({4'b0, t2_s3, 16'b0});
		pt1 = signed'({4'b0, t_s3, 32'b0});
		poly[0] = (pt2 <<< 1) - pt3 - pt1;
		poly[1] = (pt3 <<< 1) + pt3 - (pt2 <<< 2) - pt2 + TWO_Q48;
		poly[2] = (pt2 <<< 2) - (pt3 <<< 1) - pt3 + pt1;
		poly[3] = pt3 - pt2;
	end

	// Blend sums, rounded to integers and saturated.
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [RND_W-1:0] rnd_x, rnd_y;
	logic signed [COORD_BITS-1:0] sat_x, sat_y;
	logic [RND_W-COORD_BITS:0] top_x, top_y;

	always_comb begin
		sum_x = SUM_W'(prx_s5[0]) + SUM_W'(prx_s5[1]) + SUM_W'(prx_s5[2])
			+ SUM_W'(prx_s5[3]) + SUM_W'(32'sd32768);
		sum_y = SUM_W'(pry_s5[0]) + SUM_W'(pry_s5[1]) + SUM_W'(pry_s5[2])
			+ SUM_W'(pry_s5[3]) + SUM_W'(32'sd32768);
		rnd_x = sum_x[SUM_W-1:16];
		rnd_y = sum_y[SUM_W-1:16];
		top_x = rnd_x[RND_W-1:COORD_BITS-1];
		top_y = rnd_y[RND_W-1:COORD_BITS-1];
		if ((&top_x) || !(|top_x)) begin
			sat_x = rnd_x[COORD_BITS-1:0];
		end else begin
			sat_x = rnd_x[RND_W-1] ? C_MIN : C_MAX;
		end
		if ((&top_y) || !(|top_y)) begin
			sat_y = rnd_y[COORD_BITS-1:0];
		end else begin
			sat_y = rnd_y[RND_W-1] ? C_MIN : C_MAX;
		end
	end

	// Pipeline payload: t, t squared, t cubed, weights, products, output word.
	always_ff @(posedge clk) begin
		if (advance) begin
			t_s1 <= t_next;
			p1_s1 <= cmd.p1;
			last_s1 <= cmd.last;

			if (p1_s1) begin
				wsel_s2 <= WSEL_P1;
			end else if (t_s1 == T_ONE) begin
				wsel_s2 <= WSEL_END;
			end else begin
				wsel_s2 <= WSEL_CURVE;
			end
			t_s2 <= t_s1[15:0];
			t2_s2 <= t_s1[15:0] * t_s1[15:0];
			last_s2 <= last_s1;

			wsel_s3 <= wsel_s2;
			t_s3 <= t_s2;
			t2_s3 <= t2_s2;
			t3_s3 <= t2_s2 * t_s2;
			last_s3 <= last_s2;

			unique case (wsel_s3)
				WSEL_P1: begin
					b_s4[0] <= '0;
					b_s4[1] <= W_ONE;
					b_s4[2] <= '0;
					b_s4[3] <= '0;
				end
				WSEL_END: begin
					b_s4[0] <= '0;
					b_s4[1] <= '0;
					b_s4[2] <= W_ONE;
					b_s4[3] <= '0;
				end
				default: begin
					for (int i = 0; i < 4; i++) begin
						b_s4[i] <= round_weight(poly[i]);
					end
				end
			endcase
			last_s4 <= last_s3;

			for (int i = 0; i < 4; i++) begin
				prx_s5[i] <= px_q[i] * b_s4[i];
				pry_s5[i] <= py_q[i] * b_s4[i];
			end
			last_s5 <= last_s4;

			out_x_q <= sat_x;
			out_y_q <= sat_y;
			last_q <= last_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign last_of_run = last_q;

endmodule

// ----- dv/catmull_rom_tessellator_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for catmull_rom_tessellator_core: drives control point words,
// predicts every tessellated point in fixed point and checks the output words in order.
// Depends on crt_pkg and catmull_rom_tessellator_core.
module catmull_rom_tessellator_core_test;
	import crt_pkg::*;

	localparam int COORD_W = COORD_BITS_DEFAULT;
	localparam int MAX_SEG = MAX_SEG_DEFAULT;
	// Cycles to let the block settle once the last expected word has arrived.
	localparam int SETTLE_CYCLES = 80;
	localparam int REPORT_LIMIT = 10;

	// One tessellated point as the block should produce it.
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
	} spline_point_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [SEG_W-1:0]          segment_count = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic                      new_curve = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic                      last_of_run;

	// Predicted state of the block: window of the three newest points and the count.
	logic signed [COORD_W-1:0] win_x [3];
	logic signed [COORD_W-1:0] win_y [3];
	logic [1:0]                pts_seen = 2'd0;
	bit                        primed = 1'b0;
	logic [SEG_W-1:0]          seg_cfg = SEG_RESET;

	spline_point_t expected_points[$];
	int unsigned   fail_count = 0;
	int unsigned   words_checked = 0;
	int unsigned   gap_pct = 0;
	int unsigned   stall_pct = 0;

	catmull_rom_tessellator_core #(
		.MAX_SEGMENTS(MAX_SEG),
		.COORD_BITS(COORD_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.segment_count(segment_count),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.new_curve(new_curve),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.last_of_run(last_of_run)
	);

	always #1 clk = ~clk;

	// The run must end well within this time even with the heaviest stalls.
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: stalls at random with the current stall percentage.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= stall_pct);
	end

	// Each accepted output word is compared with the oldest predicted point.
	always @(posedge clk) begin
		spline_point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				if (fail_count < REPORT_LIMIT)
					$display("ERROR: unexpected word x=%0d y=%0d last=%0b",
						out_x, out_y, last_of_run);
				fail_count++;
			end else begin
				want = expected_points.pop_front();
				if (want.x !== out_x || want.y !== out_y || want.last !== last_of_run) begin
					if (fail_count < REPORT_LIMIT)
						$display("ERROR: word %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
							words_checked, want.x, want.y, want.last, out_x, out_y, last_of_run);
					fail_count++;
				end
			end
			words_checked++;
		end
	end

	// Rounds twice a weight in Q48 to Q2.16, halves toward plus infinity.
	function automatic longint weight_q16(input longint twice_q48);
		return (twice_q48 + (longint'(1) <<< 32)) >>> 33;
	endfunction

	// Rounds a Q16 sum to an integer and clamps it to the coordinate range.
	function automatic logic signed [COORD_W-1:0] round_clamp(input longint acc);
		longint v;
		longint hi;
		v = (acc + (longint'(1) <<< 15)) >>> 16;
		hi = (longint'(1) <<< (COORD_W - 1)) - 1;
		if (v > hi)
			v = hi;
		if (v < -hi - 1)
			v = -hi - 1;
		return v[COORD_W-1:0];
	endfunction

	// Works out the points that one accepted control point causes and queues them.
	task automatic tessellate_expected(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic nc);
		longint cx [4];
		longint cy [4];
		longint w [4];
		longint n, j, t, t1, t2, t3, unit;
		int i;
		spline_point_t pt;
		if (nc) begin
			pts_seen = 2'd0;
			primed = 1'b0;
		end
		if (pts_seen == 2'd3) begin
			for (i = 0; i < 3; i++) begin
				cx[i] = win_x[i];
				cy[i] = win_y[i];
			end
			cx[3] = px;
			cy[3] = py;
			n = seg_cfg;
			if (n < 1)
				n = 1;
			if (n > MAX_SEG)
				n = MAX_SEG;
			// The first segment of a curve starts with its second control point.
			if (!primed) begin
				pt.x = win_x[1];
				pt.y = win_y[1];
				pt.last = 1'b0;
				expected_points = {expected_points, pt};
				primed = 1'b1;
			end
			unit = longint'(1) <<< 48;
			for (j = 1; j <= n; j++) begin
				t = (j * 65536 + n / 2) / n;
				t1 = t <<< 32;
				t2 = (t * t) <<< 16;
				t3 = t * t * t;
				w[0] = weight_q16(-t3 + 2 * t2 - t1);
				w[1] = weight_q16(3 * t3 - 5 * t2 + 2 * unit);
				w[2] = weight_q16(-3 * t3 + 4 * t2 + t1);
				w[3] = weight_q16(t3 - t2);
				pt.x = round_clamp(cx[0] * w[0] + cx[1] * w[1] + cx[2] * w[2] + cx[3] * w[3]);
				pt.y = round_clamp(cy[0] * w[0] + cy[1] * w[1] + cy[2] * w[2] + cy[3] * w[3]);
				pt.last = (j == n);
				expected_points = {expected_points, pt};
			end
		end
		// Shift the new point into the window.
		win_x[0] = win_x[1];
		win_x[1] = win_x[2];
		win_x[2] = px;
		win_y[0] = win_y[1];
		win_y[1] = win_y[2];
		win_y[2] = py;
		if (pts_seen != 2'd3)
			pts_seen++;
	endtask

	// Offers one control point word, after a random gap, and waits for acceptance.
	// Valid stays high afterwards so that back-to-back words need no lowering.
	task automatic offer_point(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic nc);
		if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < gap_pct);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		new_curve <= nc;
		do @(posedge clk); while (!in_ready);
		tessellate_expected(px, py, nc);
	endtask

	// Stops sending and waits until every predicted point has come out.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the segment count once the block is idle.
	task automatic write_segment_count(input logic [SEG_W-1:0] value);
		wait_drain();
		cfg_valid <= 1'b1;
		segment_count <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seg_cfg = value;
	endtask

	// Draws a coordinate: full range, near the origin, or at the extremes.
	function automatic logic signed [COORD_W-1:0] pick_coord(input int unsigned style);
		logic signed [COORD_W-1:0] v;
		v = COORD_W'($urandom);
		if (style == 1)
			v = COORD_W'($signed($urandom_range(4000, 0)) - 2000);
		else if (style == 2) begin
			case ($urandom_range(2, 0))
				0: v = {1'b1, {(COORD_W-1){1'b0}}};
				1: v = {1'b0, {(COORD_W-1){1'b1}}};
				default: ;
			endcase
		end
		return v;
	endfunction

	// A curve built from the extreme coordinates, with the count left at its reset value.
	task automatic test_extreme_points();
		offer_point(-16'sd32768, 16'sd32767, 1'b1);
		offer_point(16'sd32767, -16'sd32768, 1'b0);
		offer_point(-16'sd32768, -16'sd32768, 1'b0);
		offer_point(16'sd32767, 16'sd32767, 1'b0);
		offer_point(-16'sd32768, 16'sd32767, 1'b0);
		offer_point(16'sd0, 16'sd0, 1'b0);
	endtask

	// New curve flags at the start and before the window fills, then a curve that fills and runs on.
	task automatic test_curve_restart();
		offer_point(16'sd100, -16'sd200, 1'b1);
		offer_point(16'sd300, 16'sd50, 1'b0);
		offer_point(-16'sd40, 16'sd700, 1'b0);
		offer_point(16'sd1, 16'sd2, 1'b1);
		offer_point(16'sd5, 16'sd6, 1'b0);
		offer_point(16'sd9, -16'sd3, 1'b0);
		offer_point(16'sd12, 16'sd40, 1'b0);
		offer_point(-16'sd7, -16'sd7, 1'b0);
	endtask

	// A count of zero acts as one; the largest count gives the longest runs.
	task automatic test_segment_limits();
		write_segment_count('0);
		offer_point(16'sd10, 16'sd20, 1'b1);
		offer_point(-16'sd30, 16'sd40, 1'b0);
		offer_point(16'sd500, -16'sd600, 1'b0);
		offer_point(16'sd7000, 16'sd8000, 1'b0);
		write_segment_count('1);
		offer_point(-16'sd1000, 16'sd1000, 1'b1);
		offer_point(16'sd2000, 16'sd3000, 1'b0);
		offer_point(16'sd2500, -16'sd3500, 1'b0);
		offer_point(-16'sd32768, 16'sd32767, 1'b0);
		offer_point(16'sd12345, -16'sd4321, 1'b0);
	endtask

	// Random curves under one idling pattern, in two halves, each with its own count.
	// Most curves are well formed; a few are cut short or restarted midway.
	task automatic test_random_curves(input int unsigned gap, input int unsigned stall,
			input int unsigned words, input logic [SEG_W-1:0] seg_first,
			input logic [SEG_W-1:0] seg_second);
		int unsigned half, sent, len, k, style;
		logic nc;
		gap_pct = gap;
		stall_pct = stall;
		for (half = 0; half < 2; half++) begin
			write_segment_count(half == 0 ? seg_first : seg_second);
			sent = 0;
			while (sent < words / 2) begin
				if ($urandom_range(7, 0) == 0)
					len = $urandom_range(3, 1);
				else
					len = $urandom_range(14, 4);
				style = $urandom_range(2, 0);
				for (k = 0; k < len && sent < words / 2; k++) begin
					nc = (k == 0) || ($urandom_range(24, 0) == 0);
					offer_point(pick_coord(style), pick_coord(style), nc);
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_points();
		test_curve_restart();
		test_segment_limits();
		test_random_curves(0, 0, 86, 6'd16, 6'd1);
		test_random_curves(75, 0, 86, 6'd63, SEG_W'($urandom_range(12, 2)));
		test_random_curves(0, 75, 86, 6'd0, SEG_W'($urandom_range(63, 1)));
		test_random_curves(24, 24, 86, SEG_W'($urandom_range(8, 1)), 6'd63);
		wait_drain();
		fail_count += expected_points.size();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/crt_pkg.sv
hw/rtl/crt_div.sv
hw/rtl/crt_ctrl.sv
hw/rtl/crt_datapath.sv
hw/rtl/catmull_rom_tessellator_core.sv
dv/catmull_rom_tessellator_core_test.sv
